@@ rtl/jsu_pkg.sv @@
// Shared types, codes and UTF-8 helpers for the JSON string unescape unit.
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_ESC   = 3'd1,
        ERR_HEX   = 3'd2,
        ERR_TRUNC = 3'd3,
        ERR_CTRL  = 3'd4
    } t_err;

    // One decoded unit of work: up to two code points, emitted A then B.
    // An error entry carries no code points and emits one zero byte.
    // b_raw marks B as a plain input byte that goes out unchanged.
    typedef struct packed {
        logic        a_vld;
        logic [15:0] a_cp;
        logic        b_vld;
        logic [20:0] b_cp;
        logic        b_raw;
        logic        last;
        t_err        err;
    } t_job;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // Number of UTF-8 bytes minus one.
    function automatic logic [1:0] utf8_lenm1(input logic [20:0] cp);
        logic [1:0] r;
        if (cp < 21'h80) begin
            r = 2'd0;
        end else if (cp < 21'h800) begin
            r = 2'd1;
        end else if (cp < 21'h10000) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] lenm1,
                                             input logic [1:0] idx);
        logic [7:0] r;
        unique case ({lenm1, idx})
            4'b00_00: r = cp[7:0];
            4'b01_00: r = 8'hC0 | {3'd0, cp[10:6]};
            4'b10_00: r = 8'hE0 | {4'd0, cp[15:12]};
            4'b10_01: r = 8'h80 | {2'd0, cp[11:6]};
            4'b11_00: r = 8'hF0 | {5'd0, cp[20:18]};
            4'b11_01: r = 8'h80 | {2'd0, cp[17:12]};
            4'b11_10: r = 8'h80 | {2'd0, cp[11:6]};
            default:  r = 8'h80 | {2'd0, cp[5:0]};
        endcase
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/jsu_front.sv @@
// Front end: escape parser that turns input bytes into code point jobs.
`default_nettype none

module jsu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output logic               o_ready,
    input  wire logic          i_full,
    output logic               o_push,
    output jsu_pkg::t_job      o_job
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        PH_NORMAL, PH_ESC, PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [11:0] r_hex, n_hex;
    logic [15:0] r_pend, n_pend;
    logic        r_pend_vld, n_pend_vld;
    logic        r_err, n_err;

    logic        accept;
    logic        do_err;
    t_err        err_code;
    logic [4:0]  hv;
    logic [15:0] cp;
    logic [7:0]  esc_d;
    logic        esc_ok;
    logic        is_ctrl;
    t_job        job;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign hv      = hex_digit(i_byte);
    assign cp      = {r_hex, hv[3:0]};
    assign is_ctrl = (i_byte < 8'h20) && !(i_byte >= 8'h09 && i_byte <= 8'h0D);

    always_comb begin
        esc_ok = 1'b1;
        unique case (i_byte)
            8'h22:   esc_d = 8'h22;
            8'h27:   esc_d = 8'h27;
            8'h5C:   esc_d = 8'h5C;
            8'h2F:   esc_d = 8'h2F;
            8'h6E:   esc_d = 8'h0A;
            8'h72:   esc_d = 8'h0D;
            8'h74:   esc_d = 8'h09;
            8'h62:   esc_d = 8'h08;
            8'h66:   esc_d = 8'h0C;
            default: begin
                esc_d  = 8'h00;
                esc_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_hex      = r_hex;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_err      = r_err;
        do_err     = 1'b0;
        err_code   = ERR_NONE;
        job        = '0;
        if (!r_err) begin
            unique case (r_phase)
                PH_NORMAL: begin
                    if (i_byte == CH_BSLASH) begin
                        if (i_last) begin
                            do_err   = 1'b1;
                            err_code = ERR_TRUNC;
                        end else begin
                            n_phase = PH_ESC;
                        end
                    end else if (is_ctrl) begin
                        do_err   = 1'b1;
                        err_code = ERR_CTRL;
                    end else begin
                        job.a_vld  = r_pend_vld;
                        job.a_cp   = r_pend;
                        job.b_vld  = 1'b1;
                        job.b_cp   = {13'd0, i_byte};
                        job.b_raw  = 1'b1;
                        n_pend     = '0;
                        n_pend_vld = 1'b0;
                    end
                end
                PH_ESC: begin
                    if (i_byte == CH_U) begin
                        if (i_last) begin
                            do_err   = 1'b1;
                            err_code = ERR_TRUNC;
                        end else begin
                            n_phase = PH_HEX0;
                            n_hex   = '0;
                        end
                    end else if (!esc_ok) begin
                        do_err   = 1'b1;
                        err_code = ERR_ESC;
                    end else begin
                        n_phase    = PH_NORMAL;
                        job.a_vld  = r_pend_vld;
                        job.a_cp   = r_pend;
                        job.b_vld  = 1'b1;
                        job.b_cp   = {13'd0, esc_d};
                        n_pend     = '0;
                        n_pend_vld = 1'b0;
                    end
                end
                PH_HEX0, PH_HEX1, PH_HEX2: begin
                    if (i_last) begin
                        do_err   = 1'b1;
                        err_code = ERR_TRUNC;
                    end else if (!hv[4]) begin
                        do_err   = 1'b1;
                        err_code = ERR_HEX;
                    end else begin
                        n_hex = {r_hex[7:0], hv[3:0]};
                        unique case (r_phase)
                            PH_HEX0: n_phase = PH_HEX1;
                            PH_HEX1: n_phase = PH_HEX2;
                            default: n_phase = PH_HEX3;
                        endcase
                    end
                end
                PH_HEX3: begin
                    if (!hv[4]) begin
                        do_err   = 1'b1;
                        err_code = ERR_HEX;
                    end else begin
                        n_phase = PH_NORMAL;
                        n_hex   = '0;
                        if (r_pend_vld && r_pend >= 16'hD800 && r_pend <= 16'hDBFF
                            && cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                            // surrogate pair -> one supplementary code point
                            job.b_vld  = 1'b1;
                            job.b_cp   = {1'b0, r_pend[9:0], cp[9:0]} + 21'h10000;
                            n_pend     = '0;
                            n_pend_vld = 1'b0;
                        end else begin
                            job.a_vld  = r_pend_vld;
                            job.a_cp   = r_pend;
                            job.b_vld  = i_last;
                            job.b_cp   = {5'd0, cp};
                            n_pend     = cp;
                            n_pend_vld = 1'b1;
                        end
                    end
                end
                default: begin
                    do_err   = 1'b1;
                    err_code = ERR_HEX;
                end
            endcase
        end
        if (do_err) begin
            job     = '0;
            job.err = err_code;
        end
        job.last = i_last;
        if (i_last || do_err) begin
            n_phase    = PH_NORMAL;
            n_hex      = '0;
            n_pend     = '0;
            n_pend_vld = 1'b0;
            n_err      = do_err && !i_last;
        end
    end

    assign o_job  = job;
    assign o_push = accept && !r_err && (do_err || job.a_vld || job.b_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NORMAL;
            r_hex      <= '0;
            r_pend     <= '0;
            r_pend_vld <= 1'b0;
            r_err      <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_hex      <= n_hex;
            r_pend     <= n_pend;
            r_pend_vld <= n_pend_vld;
            r_err      <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jsu_fifo.sv @@
// Small job queue between the parser and the byte emitter.
`default_nettype none

module jsu_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jsu_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output jsu_pkg::t_job      o_job
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/jsu_back.sv @@
// Back end: expands queued jobs into UTF-8 bytes, one per cycle unless stalled, into an output register.
`default_nettype none

module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire jsu_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic               o_run_last,
    output logic               o_string_end,
    output jsu_pkg::t_err      o_err
);
    import jsu_pkg::*;

    logic        r_busy;
    t_job        r_job;
    logic        r_on_b;
    logic [1:0]  r_idx;
    logic        r_out_vld;
    logic [7:0]  r_out_byte;
    logic        r_out_run;
    logic        r_out_end;
    t_err        r_out_err;

    logic [20:0] cur_cp;
    logic [1:0]  lenm1;
    logic        cp_end;
    logic        is_err;
    logic        fin;
    logic        advance;
    logic [7:0]  cur_byte;

    assign cur_cp   = r_on_b ? r_job.b_cp : {5'd0, r_job.a_cp};
    // a raw input byte goes out as a single byte, whatever its value
    assign lenm1    = (r_on_b && r_job.b_raw) ? 2'd0 : utf8_lenm1(cur_cp);
    assign cp_end   = (r_idx == lenm1);
    assign is_err   = (r_job.err != ERR_NONE);
    assign fin      = is_err || (cp_end && (r_on_b || !r_job.b_vld));
    assign cur_byte = is_err ? 8'h00 : utf8_byte(cur_cp, lenm1, r_idx);
    assign advance  = r_busy && (!r_out_vld || i_ready);
    assign o_pop    = ((advance && fin) || !r_busy) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_on_b    <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_on_b <= !i_job.a_vld;
                r_idx  <= '0;
            end else if (advance) begin
                if (fin) begin
                    r_busy <= 1'b0;
                end else if (cp_end) begin
                    r_on_b <= 1'b1;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (advance) begin
            r_out_byte <= cur_byte;
            r_out_run  <= fin;
            r_out_end  <= fin && r_job.last;
            r_out_err  <= r_job.err;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_byte       = r_out_byte;
    assign o_run_last   = r_out_run;
    assign o_string_end = r_out_end;
    assign o_err        = r_out_err;

endmodule

`default_nettype wire

@@ rtl/json_string_unescape_utf8_unit.sv @@
// Top level of the streaming JSON string unescape to UTF-8 unit.
// Takes one byte of a JSON string body per transfer (tlast on the final byte)
// and emits the decoded UTF-8 bytes. The input side accepts one byte every
// cycle while the job queue has room; the output side delivers one result
// byte per cycle while the sink is ready, set by the single byte emitter
// behind the queue. A plain byte gives one output byte, a \u or surrogate-pair
// character up to four, and a string end with two code points still to flush
// up to six, so bursts of multi-byte characters are absorbed by FIFO_DEPTH
// queued jobs before the input stalls. An input byte passes a queue entry, the
// emitter's job register and its output register. Errors give a single zero
// byte with a nonzero error code; the rest of that string is dropped.
`default_nettype none

module json_string_unescape_utf8_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // string_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,   // string_end
    output logic [3:0]       m_axis_tuser    // [0] run_last, [3:1] error_code
);
    import jsu_pkg::*;

    logic push, full, pop, empty;
    t_job wr_job, rd_job;
    t_err out_err;
    logic run_last;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_full  (full),
        .o_push  (push),
        .o_job   (wr_job)
    );

    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (wr_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (rd_job)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_job        (rd_job),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_run_last   (run_last),
        .o_string_end (m_axis_tlast),
        .o_err        (out_err)
    );

    assign m_axis_tuser = {out_err, run_last};

endmodule

`default_nettype wire

@@ rtl/jsu_checker.sv @@
// Port-level checks for the unescape unit, bound to the top level.
`default_nettype none

module jsu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic [3:0] m_axis_tuser
);
    import jsu_pkg::*;

    // string end is always the last byte of its run
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("string end without run_last");

    // an error result is a lone zero byte
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[3:1] != ERR_NONE)
        |-> (m_axis_tdata == 8'h00) && m_axis_tuser[0])
        else $error("malformed error result");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[3:1] <= ERR_CTRL))
        else $error("error code out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the JSON string unescape to UTF-8 unit.
`timescale 1ns / 100ps

module tb;
    import jsu_pkg::*;

    localparam int         HOLD_CYCLES = 80;
    localparam int         HOLD_AFTER  = 120;
    localparam int         DRAIN_WAIT  = 20;
    localparam int         RAND_ITEMS  = 220;
    localparam logic [2:0] PH_TEXT     = 3'd0;
    localparam logic [2:0] PH_ESC      = 3'd1;
    localparam logic [2:0] PH_HEX0     = 3'd2;
    localparam logic [2:0] PH_HEX3     = 3'd5;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
        t_err       err;
    } t_dec;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
    } t_body_item;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tready = 1'b0;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [3:0] m_axis_tuser;

    // decoder state mirror
    logic [2:0]  esc_phase    = PH_TEXT;
    logic [15:0] hex_acc      = 16'h0000;
    logic [15:0] pend_cp      = 16'h0000;
    logic        pend_vld     = 1'b0;
    logic        err_latched  = 1'b0;

    t_dec       step_bytes[$];
    t_dec       decoded_q[$];
    t_body_item body_q[$];
    logic [7:0] str_bytes[$];

    int src_idle_cnt  = 0;
    int rx_idle_cnt   = 0;
    int bytes_sent    = 0;
    int bytes_seen    = 0;
    int mismatches    = 0;
    int error_results = 0;
    int items_built   = 0;
    int strings_built = 0;
    int hold_cnt      = 0;
    logic rx_hold     = 1'b0;
    logic hold_done   = 1'b0;

    json_string_unescape_utf8_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic int hex_nibble(input logic [7:0] c);
        int r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = int'(c) - 48;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = int'(c) - 87;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = int'(c) - 55;
        end else begin
            r = -1;
        end
        return r;
    endfunction

    // \" \' \\ \/ n r t b f
    function automatic bit is_escape_char(input logic [7:0] c);
        return c == 8'h22 || c == 8'h27 || c == 8'h5C || c == 8'h2F || c == 8'h6E ||
               c == 8'h72 || c == 8'h74 || c == 8'h62 || c == 8'h66;
    endfunction

    task automatic note_fail(input string msg);
        if (mismatches < 10) begin
            $display("%s", msg);
        end
        mismatches++;
    endtask

    task automatic clear_decoder();
        esc_phase   = PH_TEXT;
        hex_acc     = 16'h0000;
        pend_cp     = 16'h0000;
        pend_vld    = 1'b0;
        err_latched = 1'b0;
    endtask

    task automatic put_byte(input logic [7:0] b);
        step_bytes.insert(step_bytes.size(),
                          '{data: b, run_last: 1'b0, str_end: 1'b0, err: ERR_NONE});
    endtask

    task automatic put_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic flush_pending();
        if (pend_vld) begin
            put_utf8({5'd0, pend_cp});
        end
        pend_vld = 1'b0;
        pend_cp  = 16'h0000;
    endtask

    // Errors give one zero byte; a pending code point is dropped.
    task automatic flag_error(input t_err code, input logic last);
        decoded_q.insert(decoded_q.size(),
                         '{data: 8'h00, run_last: 1'b1, str_end: last, err: code});
        clear_decoder();
        err_latched = !last;
        error_results++;
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic last);
        logic [7:0]  d;
        logic [15:0] cp;
        logic [20:0] merged;
        int          nib;
        t_dec        tail;
        step_bytes.delete();
        if (err_latched) begin
            if (last) begin
                clear_decoder();
            end
            return;
        end
        if (esc_phase == PH_TEXT) begin
            if (c == CH_BSLASH) begin
                if (last) begin
                    flag_error(ERR_TRUNC, last);
                    return;
                end
                esc_phase = PH_ESC;
            end else if (c < 8'h20 && !(c >= 8'h09 && c <= 8'h0D)) begin
                flag_error(ERR_CTRL, last);
                return;
            end else begin
                flush_pending();
                put_byte(c);
            end
        end else if (esc_phase == PH_ESC) begin
            if (c == CH_U) begin
                if (last) begin
                    flag_error(ERR_TRUNC, last);
                    return;
                end
                esc_phase = PH_HEX0;
                hex_acc   = 16'h0000;
                return;
            end
            case (c)
                8'h22, 8'h27, 8'h5C, 8'h2F: d = c;
                8'h6E: d = 8'h0A;
                8'h72: d = 8'h0D;
                8'h74: d = 8'h09;
                8'h62: d = 8'h08;
                8'h66: d = 8'h0C;
                default: begin
                    flag_error(ERR_ESC, last);
                    return;
                end
            endcase
            esc_phase = PH_TEXT;
            flush_pending();
            put_byte(d);
        end else begin
            nib = hex_nibble(c);
            // truncation wins over a bad digit
            if (last && esc_phase < PH_HEX3) begin
                flag_error(ERR_TRUNC, last);
                return;
            end
            if (nib < 0) begin
                flag_error(ERR_HEX, last);
                return;
            end
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (esc_phase < PH_HEX3) begin
                esc_phase = esc_phase + 3'd1;
                return;
            end
            esc_phase = PH_TEXT;
            cp        = hex_acc;
            hex_acc   = 16'h0000;
            if (pend_vld && pend_cp >= 16'hD800 && pend_cp <= 16'hDBFF &&
                cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                merged = ((({5'd0, pend_cp} - 21'h0D800) << 10) | ({5'd0, cp} - 21'h0DC00))
                         + 21'h10000;
                pend_vld = 1'b0;
                pend_cp  = 16'h0000;
                put_utf8(merged);
            end else begin
                flush_pending();
                pend_cp  = cp;
                pend_vld = 1'b1;
            end
        end
        if (last) begin
            flush_pending();
            clear_decoder();
        end
        if (step_bytes.size() > 0) begin
            tail          = step_bytes.pop_back();
            tail.run_last = 1'b1;
            tail.str_end  = last;
            step_bytes.insert(step_bytes.size(), tail);
        end
        foreach (step_bytes[i]) begin
            decoded_q.insert(decoded_q.size(), step_bytes[i]);
        end
    endtask

    // ---------------- stimulus construction ----------------

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            str_bytes.insert(str_bytes.size(), s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = (upper ? 8'h37 : 8'h57) + {4'd0, nib};
        end
        return r;
    endfunction

    task automatic push_hex_escape(input logic [15:0] cp);
        str_bytes.insert(str_bytes.size(), CH_BSLASH);
        str_bytes.insert(str_bytes.size(), CH_U);
        for (int k = 3; k >= 0; k--) begin
            str_bytes.insert(str_bytes.size(),
                             hex_char(cp[k*4 +: 4], $urandom_range(0, 1) == 1));
        end
    endtask

    // Moves the built string to the driver queue, tlast on its final byte.
    task automatic commit_string();
        bit         quiet;
        t_body_item it;
        // no source gaps around the receiver hold-off so the input backs up
        quiet = (items_built >= 100 && items_built < 210) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < str_bytes.size(); i++) begin
            it.data = str_bytes[i];
            it.last = (i == str_bytes.size() - 1);
            it.gap  = quiet ? 0 : $urandom_range(0, 8);
            body_q.insert(body_q.size(), it);
            items_built++;
        end
        str_bytes.delete();
        strings_built++;
    endtask

    function automatic logic [15:0] pick_code_point();
        logic [15:0] r;
        case ($urandom_range(0, 5))
            0: r = 16'($urandom_range(0, 16'h007F));
            1: r = 16'($urandom_range(16'h0080, 16'h07FF));
            2: r = 16'($urandom_range(16'h0800, 16'hFFFF));
            3: r = 16'($urandom_range(16'hD800, 16'hDBFF));
            4: r = 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: r = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        endcase
        return r;
    endfunction

    task automatic build_random_string();
        int         tokens;
        int         sel;
        int         pos;
        logic [7:0] b;
        logic [7:0] esc_set[9];
        esc_set = '{8'h22, 8'h27, 8'h5C, 8'h2F, 8'h6E, 8'h72, 8'h74, 8'h62, 8'h66};
        tokens = $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                case ($urandom_range(0, 3))
                    1: b = 8'($urandom_range(8'h80, 8'hFF));
                    2: b = 8'($urandom_range(8'h09, 8'h0D));
                    default: begin
                        do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CH_BSLASH);
                    end
                endcase
                str_bytes.insert(str_bytes.size(), b);
            end else if (sel < 48) begin
                str_bytes.insert(str_bytes.size(), CH_BSLASH);
                str_bytes.insert(str_bytes.size(), esc_set[$urandom_range(0, 8)]);
            end else if (sel < 72) begin
                push_hex_escape(pick_code_point());
            end else if (sel < 92) begin
                push_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                push_hex_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end else begin
                case ($urandom_range(0, 3))
                    0: str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 8'h1F)));
                    1: begin
                        do b = 8'($urandom_range(0, 255)); while (is_escape_char(b) || b == CH_U);
                        str_bytes.insert(str_bytes.size(), CH_BSLASH);
                        str_bytes.insert(str_bytes.size(), b);
                    end
                    2: begin
                        push_hex_escape(pick_code_point());
                        do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
                        pos = str_bytes.size() - 1 - $urandom_range(0, 3);
                        str_bytes[pos] = b;
                    end
                    default: str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 255)));
                endcase
            end
        end
        // cut some strings short to land tlast inside an escape
        if ($urandom_range(0, 7) == 0) begin
            pos = $urandom_range(1, str_bytes.size());
            while (str_bytes.size() > pos) begin
                void'(str_bytes.pop_back());
            end
        end
    endtask

    // ---------------- source side ----------------

    always @(posedge i_clk) begin : src_drv
        t_body_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_idle_cnt  <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (body_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (src_idle_cnt < body_q[0].gap) begin
                    s_axis_tvalid <= 1'b0;
                    src_idle_cnt  <= src_idle_cnt + 1;
                end else begin
                    nxt = body_q.pop_front();
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.last;
                    s_axis_tvalid <= 1'b1;
                    src_idle_cnt  <= 0;
                end
            end
        end
    end

    // ---------------- sink side ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold   <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (rx_hold) begin
            if (hold_cnt == HOLD_CYCLES - 1) begin
                rx_hold   <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_cnt <= hold_cnt + 1;
        end else if (!hold_done && bytes_sent >= HOLD_AFTER) begin
            rx_hold <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : sink_mon
        t_dec exp_b;
        int   w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_idle_cnt   <= 0;
        end else begin
            w = rx_idle_cnt;
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    note_fail($sformatf("tb: unexpected out byte %02h tuser %h end %b",
                                        m_axis_tdata, m_axis_tuser, m_axis_tlast));
                end else begin
                    exp_b = decoded_q.pop_front();
                    if (m_axis_tdata !== exp_b.data || m_axis_tuser[0] !== exp_b.run_last ||
                        m_axis_tlast !== exp_b.str_end || m_axis_tuser[3:1] !== exp_b.err) begin
                        note_fail($sformatf(
                            "tb: out #%0d exp data %02h rl %b end %b err %0d, got %02h %b %b %0d",
                            bytes_seen, exp_b.data, exp_b.run_last, exp_b.str_end, exp_b.err,
                            m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[3:1]));
                    end
                end
                bytes_seen++;
                // every third window of transfers runs without sink stalls
                w = ((bytes_seen / 48) % 3 == 1) ? 0 : $urandom_range(0, 8);
            end else if (w > 0) begin
                w--;
            end
            rx_idle_cnt   <= w;
            m_axis_tready <= (w == 0) && !rx_hold;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        // directed: surrogate pair merge, bad escape then dropped tail,
        // cut-off hex, control char, high byte, lone backslash, flush on next byte
        push_text("\\uD83D\\uDE00");
        commit_string();
        push_text("\\qz");
        commit_string();
        push_text("\\u12");
        commit_string();
        str_bytes.insert(str_bytes.size(), 8'h00);
        commit_string();
        str_bytes.insert(str_bytes.size(), 8'hFF);
        commit_string();
        push_text("\\");
        commit_string();
        push_text("\\u00E9A");
        commit_string();
        while (items_built < RAND_ITEMS) begin
            build_random_string();
            commit_string();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (body_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            note_fail($sformatf("tb: %0d expected out bytes never arrived", decoded_q.size()));
        end

        $display("tb: %0d strings, %0d body bytes in, %0d UTF-8 bytes out (%0d error results)",
                 strings_built, bytes_sent, bytes_seen, error_results);
        $display("tb: sink held off %0d cycles once; %0d mismatches", HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
